[hw/rtl/sbs_pkg.sv]
// Shared types and constants for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package sbs_pkg;

   // Field widths
   localparam int BYTE_W      = 8;
   localparam int ENTRY_IDX_W = 6;
   localparam int CFG_LEN_W   = 7;
   localparam int COUNT_W     = 32;

   // Default number of pattern entries (cells in the window chain)
   localparam int DEF_MAX_PATTERN = 64;

   // Request kinds carried in req_tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   // Reset value of the length register
   localparam logic [CFG_LEN_W-1:0] CFG_LEN_RESET = 7'd1;

   // One pattern entry: expected byte plus wildcard mark
   typedef struct packed {
      logic              wild;
      logic [BYTE_W-1:0] value;
   } pattern_entry_type;

   localparam int ENTRY_BITS = $bits(pattern_entry_type);

   // Per-cell control from the sequencing logic
   typedef struct packed {
      logic shift;   // take the neighbor's byte this cycle
      logic active;  // position lies inside the current pattern length
   } cell_ctrl_type;

endpackage

[hw/rtl/sbs_align.sv]
// Pattern aligner: lines up pattern entries with window ages for the current length.
`timescale 1ns / 1ps

module sbs_align
   import sbs_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic              clock,
   input  pattern_entry_type table_entry [MAX_PATTERN],
   input  logic [LEN_W-1:0]  shift_amt,
   output pattern_entry_type aligned     [MAX_PATTERN]
);

   localparam int VEC_W = MAX_PATTERN * ENTRY_BITS;

   logic [VEC_W-1:0] stage_vec [LEN_W+1];
   logic [VEC_W-1:0] aligned_ff;

   // Reverse the table so that the entry for age k sits at MAX-len+k
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         stage_vec[0][i*ENTRY_BITS +: ENTRY_BITS] = table_entry[MAX_PATTERN-1-i];
      end
   end

   // Log shifter down by (MAX - len) entries
   for (genvar b = 0; b < LEN_W; b++) begin : g_shift
      assign stage_vec[b+1] = shift_amt[b] ?
                              (stage_vec[b] >> (ENTRY_BITS * (1 << b))) : stage_vec[b];
   end

   always_ff @(posedge clock) begin
      aligned_ff <= stage_vec[LEN_W];
   end

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         aligned[k] = aligned_ff[k*ENTRY_BITS +: ENTRY_BITS];
      end
   end

endmodule

[hw/rtl/sbs_cell.sv]
// Window cell: holds one byte of the scan window and checks it against its pattern entry.
`timescale 1ns / 1ps

module sbs_cell
   import sbs_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [BYTE_W-1:0] byte_in,
   input  pattern_entry_type entry,
   output logic [BYTE_W-1:0] byte_out,
   output logic              hit
);

   logic [BYTE_W-1:0] window_ff;

   // Shift the neighbor's byte in on every accepted data byte
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         window_ff <= byte_in;
      end
   end

   assign byte_out = window_ff;

   // Positions beyond the pattern length always agree
   assign hit = !ctrl.active || entry.wild || (entry.value == window_ff);

endmodule

[hw/rtl/wildcard_byte_pattern_scanner_top.sv]
// Top level of the wildcard byte pattern scanner: request handling, window chain, result.
// A result passes the compare stage register, then the result register, to reach rsp.
// Throughput: one request per cycle while rsp is free; the window chain shifts once per
//   data byte and the full-window compare runs in the single stage after acceptance.
// Reset: synchronous; clears the scan count, match flag, pipeline and result valids
//   and sets the length register to 1. Pattern entries are not cleared.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_top
   import sbs_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [5:0] entry_index, [13:6] pattern_byte, [14] wildcard_req, [22:15] data_byte
   input  logic [23:0]          req_tdata,
   // [0] cmd
   input  logic                 req_tuser,
   input  logic                 req_tlast,
   // Result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [31:0] match_offset
   output logic [COUNT_W-1:0]   rsp_tdata,
   // [0] found
   output logic                 rsp_tuser,
   // Length register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_LEN_W-1:0] csr_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
   localparam int WIDX_W = IDX_W + ENTRY_IDX_W;

   // Request fields
   logic [ENTRY_IDX_W-1:0] entry_index;
   logic [BYTE_W-1:0]      pattern_byte;
   logic                   wildcard_req;
   logic [BYTE_W-1:0]      data_byte;

   assign entry_index  = req_tdata[5:0];
   assign pattern_byte = req_tdata[13:6];
   assign wildcard_req = req_tdata[14];
   assign data_byte    = req_tdata[22:15];

   // State
   logic [CFG_LEN_W-1:0] pattern_length_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 matched_ff, matched_in;
   logic                 s_valid_ff, s_valid_in;
   logic                 s_last_ff;
   logic [COUNT_W-1:0]   s_count_ff;
   logic [LEN_W-1:0]     s_len_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic [COUNT_W-1:0]   rsp_offset_ff;

   pattern_entry_type    pattern_ff [MAX_PATTERN];
   pattern_entry_type    aligned    [MAX_PATTERN];

   logic                 accept, data_acc, load_acc;
   logic                 out_free, s_move, s_fire;
   logic [LEN_W-1:0]     eff_len, shift_amt;
   logic [COUNT_W-1:0]   count_inc, s_len_ext;
   logic [WIDX_W-1:0]    wr_idx;
   logic                 window_hit, full_match, has_result;

   logic [BYTE_W-1:0]    chain [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] hits;

   // Handshakes
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s_move     = !s_valid_ff || out_free;
   assign req_tready = s_move;
   assign accept     = req_tvalid && req_tready;
   assign data_acc   = accept && (req_tuser == CMD_DATA);
   assign load_acc   = accept && (req_tuser == CMD_LOAD);
   assign s_fire     = s_valid_ff && s_move;
   assign csr_ready  = 1'b1;

   // Length register
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= CFG_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         pattern_length_ff <= csr_data;
      end
   end

   // Effective length: zero acts as one, clamp at table size
   always_comb begin
      logic [CMP_W-1:0] cfg_ext;
      cfg_ext = CMP_W'(pattern_length_ff);
      if (cfg_ext == '0) begin
         eff_len = LEN_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_PATTERN)) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = LEN_W'(cfg_ext);
      end
   end

   assign shift_amt = LEN_W'(MAX_PATTERN) - eff_len;

   // Pattern table write; indexes past the table are dropped
   assign wr_idx = WIDX_W'(entry_index);

   always_ff @(posedge clock) begin
      if (load_acc && (wr_idx < WIDX_W'(MAX_PATTERN))) begin
         pattern_ff[wr_idx[IDX_W-1:0]] <= '{wild: wildcard_req, value: pattern_byte};
      end
   end

   sbs_align #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_align (
      .clock       (clock),
      .table_entry (pattern_ff),
      .shift_amt   (shift_amt),
      .aligned     (aligned)
   );

   // Window chain: cell k holds the byte of age k
   assign chain[0] = data_byte;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      cell_ctrl_type ctrl;
      assign ctrl.shift  = data_acc;
      assign ctrl.active = (LEN_W'(k) < s_len_ff);

      sbs_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .byte_in  (chain[k]),
         .entry    (aligned[k]),
         .byte_out (chain[k+1]),
         .hit      (hits[k])
      );
   end

   // Byte count, saturating; cleared by the last byte of a region
   assign count_inc = (count_ff == '1) ? count_ff : (count_ff + COUNT_W'(1));

   always_comb begin
      count_in = count_ff;
      if (data_acc) begin
         count_in = req_tlast ? '0 : count_inc;
      end
   end

   // Compare stage
   assign s_len_ext  = COUNT_W'(s_len_ff);
   assign window_hit = &hits;
   assign full_match = !matched_ff && (s_count_ff >= s_len_ext) && window_hit;
   assign has_result = !matched_ff && (full_match || s_last_ff);

   always_comb begin
      s_valid_in = s_valid_ff;
      if (data_acc) begin
         s_valid_in = 1'b1;
      end else if (s_move) begin
         s_valid_in = 1'b0;
      end
   end

   // Match flag holds off further results until the region ends
   always_comb begin
      matched_in = matched_ff;
      if (s_fire) begin
         matched_in = s_last_ff ? 1'b0 : (matched_ff || full_match);
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s_fire && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         matched_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         matched_ff   <= matched_in;
         s_valid_ff   <= s_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage and result payload
   always_ff @(posedge clock) begin
      if (data_acc) begin
         s_last_ff  <= req_tlast;
         s_count_ff <= count_inc;
         s_len_ff   <= eff_len;
      end
      if (s_fire && has_result) begin
         rsp_found_ff  <= full_match;
         rsp_offset_ff <= full_match ? (s_count_ff - s_len_ext) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_offset_ff;

endmodule
